// ===== src/lebc_pkg.sv =====
// ----------------------------------------------------------------------------
// lebc_pkg
// Shared types and constants of the unsigned LEB128 codec.
// ----------------------------------------------------------------------------
package lebc_pkg;

  // group geometry
  localparam int unsigned GroupBits = 7;
  localparam int unsigned ValueBits = 64;
  localparam int unsigned RestBits  = ValueBits - GroupBits;

  // decoder shift positions
  localparam logic [6:0] TopShift  = 7'd63;
  localparam logic [6:0] DropShift = 7'd70;

  // encoder byte count, last byte index of ten
  localparam logic [3:0] LastByteIdx = 4'd9;

  // operating mode
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // controller states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_ENCODE = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic enc_load;   // accepted value, emit its first byte
    logic enc_step;   // emit next byte of stored value
    logic dec_step;   // accepted byte, fold into accumulator
    logic out_load;   // capture a result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  out_free;      // output register can take a result
    logic  enc_last_new;  // incoming value fits in one byte
    logic  enc_last_cur;  // stored value yields its final byte now
    logic  dec_done;      // incoming byte ends the value
  } status_t;

endpackage

// ===== src/lebc_in_if.sv =====
// ----------------------------------------------------------------------------
// lebc_in_if
// Input channel: value to encode or byte to decode.
// ----------------------------------------------------------------------------
interface lebc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] in_value;
  logic [7:0]  in_byte;

  modport source (output valid, in_value, in_byte, input ready);
  modport sink   (input valid, in_value, in_byte, output ready);
endinterface

// ===== src/lebc_out_if.sv =====
// ----------------------------------------------------------------------------
// lebc_out_if
// Output channel: encoded byte or decoded value.
// ----------------------------------------------------------------------------
interface lebc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last;
  logic [63:0] out_value;
  logic        overflow;

  modport source (output valid, out_byte, last, out_value, overflow, input ready);
  modport sink   (input valid, out_byte, last, out_value, overflow, output ready);
endinterface

// ===== src/lebc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lebc_cfg_if
// Configuration write channel carrying the mode register.
// ----------------------------------------------------------------------------
interface lebc_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, mode, input ready);
  modport sink   (input valid, mode, output ready);
endinterface

// ===== src/leb128_codec_core.sv =====
// ----------------------------------------------------------------------------
// leb128_codec_core
// Unsigned LEB128 encoder and decoder selected by a mode register.
// ----------------------------------------------------------------------------
// A result is registered, shown the cycle after the transfer completing it.
// Encode: a value of n bytes (1 to 10) leaves the single output register one
// byte a cycle while the sink is ready; the next value follows at once.
// Decode: one byte per cycle while out_free; value emitted on its final byte.
// Reset: mode returns to encode, decoder state and output valid are cleared.
module leb128_codec_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lebc_cfg_if.sink  cfg_i,
  lebc_in_if.sink   in_i,
  lebc_out_if.source out_o
);
  import lebc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencing
  lebc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  lebc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_i),
    .in_value_i     (in_i.in_value),
    .in_byte_i      (in_i.in_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_byte_o     (out_o.out_byte),
    .out_last_o     (out_o.last),
    .out_value_o    (out_o.out_value),
    .out_overflow_o (out_o.overflow)
  );

endmodule

// ===== src/lebc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lebc_ctrl
// Controller: sequences encode bytes and steers decode transfers.
// ----------------------------------------------------------------------------
module lebc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lebc_pkg::status_t sts_i,
  output lebc_pkg::cmd_t    cmd_o
);
  import lebc_pkg::*;

  state_e state_q, state_d;
  logic   in_xfer;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (sts_i.mode == MODE_DECODE) begin
            cmd_o.dec_step = 1'b1;
            cmd_o.out_load = sts_i.dec_done;
          end else begin
            cmd_o.enc_load = 1'b1;
            cmd_o.out_load = 1'b1;
            if (!sts_i.enc_last_new) state_d = ST_ENCODE;
          end
        end
      end
      ST_ENCODE: begin
        if (sts_i.out_free) begin
          cmd_o.enc_step = 1'b1;
          cmd_o.out_load = 1'b1;
          if (sts_i.enc_last_cur) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/lebc_dp.sv =====
// ----------------------------------------------------------------------------
// lebc_dp
// Datapath: mode register, encode shifter, decode accumulator, output register.
// ----------------------------------------------------------------------------
module lebc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  lebc_cfg_if.sink          cfg_i,
  input  logic [63:0]       in_value_i,
  input  logic [7:0]        in_byte_i,
  input  lebc_pkg::cmd_t    cmd_i,
  output lebc_pkg::status_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic [63:0]       out_value_o,
  output logic              out_overflow_o
);
  import lebc_pkg::*;

  mode_e                mode_q;
  logic [RestBits-1:0]  enc_q, enc_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [63:0]          acc_q, acc_d;
  logic [6:0]           shift_q, shift_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q;
  logic [7:0]           byte_q;
  logic                 last_q;
  logic [63:0]          value_q;
  logic                 vovf_q;
  logic                 cfg_xfer;
  logic [GroupBits-1:0] group;
  logic [GroupBits-1:0] enc_grp;
  logic                 enc_last;
  logic [7:0]           enc_byte;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid;

  // encoder byte selection
  assign sts_o.enc_last_new = (in_value_i <= 64'd127);
  assign sts_o.enc_last_cur = (enc_q <= RestBits'(127)) || (cnt_q == LastByteIdx);
  assign enc_last = cmd_i.enc_load ? sts_o.enc_last_new : sts_o.enc_last_cur;
  assign enc_grp  = cmd_i.enc_load ? in_value_i[GroupBits-1:0] : enc_q[GroupBits-1:0];
  assign enc_byte = {~enc_last, enc_grp};

  always_comb begin
    enc_d = enc_q;
    cnt_d = cnt_q;
    if (cmd_i.enc_load) begin
      enc_d = in_value_i[ValueBits-1:GroupBits];
      cnt_d = 4'd1;
    end else if (cmd_i.enc_step) begin
      enc_d = enc_q >> GroupBits;
      cnt_d = cnt_q + 4'd1;
    end
  end

  // decoder accumulate
  assign group          = in_byte_i[GroupBits-1:0];
  assign sts_o.dec_done = ~in_byte_i[7];

  always_comb begin
    acc_d   = acc_q;
    shift_d = shift_q;
    ovf_d   = ovf_q;
    if (shift_q < TopShift) begin
      acc_d   = acc_q | ({{RestBits{1'b0}}, group} << shift_q[5:0]);
      shift_d = shift_q + 7'(GroupBits);
    end else if (shift_q == TopShift) begin
      acc_d   = {acc_q[63] | group[0], acc_q[62:0]};
      ovf_d   = ovf_q | (|group[GroupBits-1:1]);
      shift_d = DropShift;
    end else begin
      ovf_d   = 1'b1;
      shift_d = DropShift;
    end
  end

  // mode and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ENCODE;
      acc_q   <= '0;
      shift_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cfg_xfer) begin
      mode_q  <= mode_e'(cfg_i.mode);
      acc_q   <= '0;
      shift_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.dec_step) begin
      if (sts_o.dec_done) begin
        acc_q   <= '0;
        shift_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        acc_q   <= acc_d;
        shift_q <= shift_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  // encoder shifter
  always_ff @(posedge clk_i) begin
    enc_q <= enc_d;
    cnt_q <= cnt_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.dec_step) begin
        byte_q  <= 8'd0;
        last_q  <= 1'b1;
        value_q <= acc_d;
        vovf_q  <= ovf_d;
      end else begin
        byte_q  <= enc_byte;
        last_q  <= enc_last;
        value_q <= 64'd0;
        vovf_q  <= 1'b0;
      end
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign out_last_o     = last_q;
  assign out_value_o    = value_q;
  assign out_overflow_o = vovf_q;

endmodule
